// ----- hdl/cvpo_pkg.sv -----
// Package for the cube vertex pattern orbit core.
// Holds the FSM state type, controller/datapath command and status structs,
// the candidate transform tables and the vertex transform functions.
package cvpo_pkg;

    localparam int PAT_W   = 8;
    localparam int IDX_W   = 5;
    localparam int N_CAND  = 32;

    // Rotation codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_Z    = 2'd1;
    localparam logic [1:0] ROT_Y    = 2'd2;
    localparam logic [1:0] ROT_X    = 2'd3;

    // Candidate order: identity, Z, Y, X, input mirrors, then mirrors of Z, Y, X
    localparam logic [1:0] CAND_ROT [N_CAND] = '{
        ROT_NONE, ROT_Z, ROT_Y, ROT_X,
        ROT_NONE, ROT_NONE, ROT_NONE, ROT_NONE, ROT_NONE, ROT_NONE, ROT_NONE,
        ROT_Z, ROT_Z, ROT_Z, ROT_Z, ROT_Z, ROT_Z, ROT_Z,
        ROT_Y, ROT_Y, ROT_Y, ROT_Y, ROT_Y, ROT_Y, ROT_Y,
        ROT_X, ROT_X, ROT_X, ROT_X, ROT_X, ROT_X, ROT_X
    };

    localparam logic [2:0] CAND_MIR [N_CAND] = '{
        3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7,
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7,
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7,
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;       // take a new request
        logic advance;    // step to the next candidate
        logic capture;    // hold current candidate as pending
        logic push;       // move pending variant to the output register
        logic push_last;  // pushed variant is the final one
    } ctrl_cmd_t;

    typedef struct packed {
        logic cand_new;   // current candidate not seen earlier
        logic cand_end;   // current candidate is the final one
        logic pend_valid; // a variant waits in the pending register
        logic out_free;   // output register can take a variant this cycle
    } dp_status_t;

    // Bits of the result are {z', y', x'}
    function automatic logic [2:0] rot_vertex(logic [2:0] v, logic [1:0] rot);
        logic [2:0] r;
        case (rot)
            ROT_Z:   r = {v[2], v[0], ~v[1]};
            ROT_Y:   r = {v[0], v[1], ~v[2]};
            ROT_X:   r = {v[1], ~v[2], v[0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [PAT_W-1:0] xform(logic [PAT_W-1:0] p, logic [1:0] rot,
                                               logic [2:0] mir);
        logic [PAT_W-1:0] r;
        r = '0;
        for (int v = 0; v < PAT_W; v++) begin
            if (p[v])
            begin
                r[rot_vertex(3'(v), rot) ^ mir] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/cube_vertex_pattern_orbit_core.sv -----
// Top level of the cube vertex pattern orbit core.
// Joins cvpo_ctrl and cvpo_dp; types come from cvpo_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | pattern[7:0]
//  out     | out_valid/out_stall | variant_pattern[7:0], variant_index[4:0], last
//
// A request is loaded, then its 32 candidates are compared with all earlier ones
// in parallel, one per cycle unless a stall holds the scan, and then flushed.
// Each distinct variant waits in a pending register so last is known when the
// final one leaves. Output stalls pause the scan only when a new variant finds
// both pending and output registers full. Reset clears the FSM and valid flags.
module cube_vertex_pattern_orbit_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pattern,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] variant_pattern,
    output logic [4:0] variant_index,
    output logic       last
);

    cvpo_pkg::ctrl_cmd_t  cmd;
    cvpo_pkg::dp_status_t status;

    cvpo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cvpo_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pattern         (pattern),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .variant_pattern (variant_pattern),
        .variant_index   (variant_index),
        .last            (last)
    );

endmodule

// ----- hdl/cvpo_dp.sv -----
// Datapath of the orbit core: pattern register, candidate counter,
// duplicate check, pending variant and output register. Uses cvpo_pkg.
module cvpo_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cvpo_pkg::ctrl_cmd_t           cmd,
    output cvpo_pkg::dp_status_t          status,
    input  logic [cvpo_pkg::PAT_W-1:0]    pattern,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cvpo_pkg::PAT_W-1:0]    variant_pattern,
    output logic [cvpo_pkg::IDX_W-1:0]    variant_index,
    output logic                          last
);

    logic [cvpo_pkg::PAT_W-1:0] pat_reg;
    logic [cvpo_pkg::IDX_W-1:0] cand_idx_reg, cand_idx_next;
    logic [cvpo_pkg::IDX_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [cvpo_pkg::PAT_W-1:0] pend_pat_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [cvpo_pkg::PAT_W-1:0] out_pat_reg;
    logic [cvpo_pkg::IDX_W-1:0] out_idx_reg;
    logic                       out_last_reg;

    logic [cvpo_pkg::PAT_W-1:0] cands [cvpo_pkg::N_CAND];
    logic [cvpo_pkg::N_CAND-1:0] hit;
    logic [cvpo_pkg::PAT_W-1:0] cand_cur;

    // All candidates are bit permutations of the held pattern
    for (genvar j = 0; j < cvpo_pkg::N_CAND; j++)
    begin : g_cand
        assign cands[j] = cvpo_pkg::xform(pat_reg, cvpo_pkg::CAND_ROT[j],
                                          cvpo_pkg::CAND_MIR[j]);
        assign hit[j]   = (cands[j] == cand_cur) &&
                          (cvpo_pkg::IDX_W'(j) < cand_idx_reg);
    end

    assign cand_cur = cands[cand_idx_reg];

    always_comb
    begin
        status.cand_new   = ~|hit;
        status.cand_end   = (cand_idx_reg == cvpo_pkg::IDX_W'(cvpo_pkg::N_CAND - 1));
        status.pend_valid = pend_valid_reg;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        cand_idx_next   = cand_idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (cmd.load)
        begin
            cand_idx_next   = '0;
            emit_cnt_next   = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.advance)
        begin
            cand_idx_next = cand_idx_reg + 1'b1;
        end
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            emit_cnt_next   = emit_cnt_reg + 1'b1;
            pend_valid_next = 1'b0;
        end
        if (cmd.capture)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_idx_reg   <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cand_idx_reg   <= cand_idx_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pat_reg <= pattern;
        end
        if (cmd.capture)
        begin
            pend_pat_reg <= cand_cur;
        end
        if (cmd.push)
        begin
            out_pat_reg  <= pend_pat_reg;
            out_idx_reg  <= emit_cnt_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign variant_pattern = out_pat_reg;
    assign variant_index   = out_idx_reg;
    assign last            = out_last_reg;

endmodule

// ----- hdl/cvpo_ctrl.sv -----
// Controller of the orbit core: sequences load, candidate scan and final
// flush, driving the datapath by commands. Uses cvpo_pkg.
module cvpo_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cvpo_pkg::dp_status_t  status,
    output cvpo_pkg::ctrl_cmd_t   cmd
);

    cvpo_pkg::state_t state_reg, state_next;
    logic             take_cand;

    // A new candidate is held back until the previous pending one can go out
    assign take_cand = status.cand_new && (!status.pend_valid || status.out_free);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvpo_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cvpo_pkg::ST_SCAN;
                end
            end
            cvpo_pkg::ST_SCAN:
            begin
                if ((!status.cand_new || take_cand) && status.cand_end)
                begin
                    state_next = cvpo_pkg::ST_FLUSH;
                end
            end
            cvpo_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = cvpo_pkg::ST_IDLE;
                end
            end
            default: state_next = cvpo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            cvpo_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            cvpo_pkg::ST_SCAN:
            begin
                cmd.capture = take_cand;
                cmd.push    = take_cand && status.pend_valid;
                cmd.advance = !status.cand_new || take_cand;
            end
            cvpo_pkg::ST_FLUSH:
            begin
                cmd.push      = status.out_free;
                cmd.push_last = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvpo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- verif/cube_vertex_pattern_orbit_core_tb.sv -----
// Testbench for cube_vertex_pattern_orbit_core: drives patterns with random gaps and output
// stalls, predicts the ordered list of distinct cube-symmetry variants for each request and
// checks every variant as it leaves. Needs only the core RTL and its package.
`timescale 1ns / 1ps

module cube_vertex_pattern_orbit_core_tb;

    typedef enum logic [1:0] {
        TURN_NONE,
        TURN_Z,
        TURN_Y,
        TURN_X
    } turn_e;

    localparam int NUM_MIRRORS = 7;
    localparam logic [2:0] MIRROR_MASKS [NUM_MIRRORS] = '{
        3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7
    };
    localparam int RANDOM_REQUESTS = 250;
    localparam int QUIET_FROM      = 200;

    typedef struct packed {
        logic [7:0] pat;
        logic [4:0] idx;
        logic       last;
    } variant_t;

    class orbit_scoreboard;
        variant_t pending_variants[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Turn every occupied vertex, then flip its index bits by the mirror mask.
        static function logic [7:0] map_pattern(logic [7:0] p, turn_e turn, logic [2:0] mask);
            logic [7:0] r;
            logic       x;
            logic       y;
            logic       z;
            logic [2:0] w;
            r = '0;
            for (int i = 0; i < 8; i++)
            begin
                x = i[0];
                y = i[1];
                z = i[2];
                case (turn)
                    TURN_Z:  w = {z, x, ~y};
                    TURN_Y:  w = {x, y, ~z};
                    TURN_X:  w = {y, ~z, x};
                    default: w = {z, y, x};
                endcase
                if (p[i])
                begin
                    r[w ^ mask] = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_pattern(logic [7:0] p);
            logic [7:0] cands[$];
            logic [7:0] kept[$];
            bit         dup;
            variant_t   e;
            for (int r = 0; r < 4; r++)
            begin
                cands.push_back(map_pattern(p, turn_e'(r), 3'd0));
            end
            for (int r = 0; r < 4; r++)
            begin
                for (int j = 0; j < NUM_MIRRORS; j++)
                begin
                    cands.push_back(map_pattern(p, turn_e'(r), MIRROR_MASKS[j]));
                end
            end
            // Keep first appearance only.
            foreach (cands[i])
            begin
                dup = 1'b0;
                foreach (kept[k])
                begin
                    if (kept[k] == cands[i])
                    begin
                        dup = 1'b1;
                    end
                end
                if (!dup)
                begin
                    kept.push_back(cands[i]);
                end
            end
            foreach (kept[i])
            begin
                e.pat  = kept[i];
                e.idx  = 5'(i);
                e.last = (i == kept.size() - 1);
                pending_variants.push_back(e);
            end
        endfunction

        function void check_variant(logic [7:0] vp, logic [4:0] vi, logic lst);
            variant_t e;
            if (pending_variants.size() == 0)
            begin
                $display("%0t: unexpected variant, actual pattern %h index %0d last %0b",
                         $time, vp, vi, lst);
                errors++;
                return;
            end
            e = pending_variants.pop_front();
            if (vp !== e.pat)
            begin
                $display("%0t: variant_pattern expected %h actual %h", $time, e.pat, vp);
                errors++;
            end
            if (vi !== e.idx)
            begin
                $display("%0t: variant_index expected %0d actual %0d", $time, e.idx, vi);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_variants.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] pattern;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] variant_pattern;
    logic [4:0] variant_index;
    logic       last;

    orbit_scoreboard orbit_sb = new();
    bit              idle_on = 1'b1;

    cube_vertex_pattern_orbit_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pattern         (pattern),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .variant_pattern (variant_pattern),
        .variant_index   (variant_index),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Present one request; hold it until the core takes it.
    task automatic send_pattern(input logic [7:0] p);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pattern  <= p;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        orbit_sb.note_pattern(p);
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (orbit_sb.outstanding() != 0);
    endtask

    // Output side: check accepted variants, stall in random bursts.
    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                orbit_sb.check_variant(variant_pattern, variant_index, last);
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 10) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic [7:0] directed [];
        logic [7:0] p;
        int         waited;
        directed = '{
            8'h00, 8'hFF, 8'h01, 8'h80, 8'h02, 8'h40, 8'h03, 8'h0F,
            8'hF0, 8'h33, 8'h55, 8'hAA, 8'h69, 8'h96, 8'h7F, 8'hFE,
            8'h81, 8'h18, 8'h17, 8'hE8, 8'h0B, 8'h3C, 8'hC3, 8'h24
        };
        rst_n    = 1'b0;
        in_valid = 1'b0;
        pattern  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty, full, single vertex, faces, tetrahedra and other symmetric shapes.
        foreach (directed[i])
        begin
            send_pattern(directed[i]);
        end

        // Hold the input until every variant so far has left.
        in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == QUIET_FROM)
            begin
                idle_on = 1'b0;
            end
            p = 8'($urandom_range(0, 255));
            // Bias some requests toward sparse or dense shapes.
            if (n % 5 == 1)
            begin
                p = p & 8'($urandom_range(0, 255));
            end
            else if (n % 5 == 3)
            begin
                p = p | 8'($urandom_range(0, 255));
            end
            send_pattern(p);
        end
        in_valid <= 1'b0;

        waited = 0;
        while (orbit_sb.outstanding() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (orbit_sb.outstanding() != 0)
        begin
            $display("%0t: %0d expected variants never arrived", $time,
                     orbit_sb.outstanding());
            orbit_sb.errors++;
        end

        if (orbit_sb.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cvpo_pkg.sv
hdl/cvpo_dp.sv
hdl/cvpo_ctrl.sv
hdl/cube_vertex_pattern_orbit_core.sv
verif/cube_vertex_pattern_orbit_core_tb.sv
